// ----- rtl/ascending_exchange_sorter_macros.svh -----
// Assertion macros used by the checker file of the ascending exchange sorter.
// Each macro expects a clock named clk and a reset named rst in the using scope.
`ifndef ASCENDING_EXCHANGE_SORTER_MACROS_SVH
`define ASCENDING_EXCHANGE_SORTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EXS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EXS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/exs_pkg.sv -----
// Shared types and constants for the ascending exchange sorter.
// No dependencies; every other file of the block but the macro header imports this package.
`default_nettype none

package exs_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int KEY_W = 8;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic [7:0] key_value;
    logic       last_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] sorted_value;
    logic       last_out;
    logic       overflowed;
  } out_item_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    key_t wdata;
    idx_t raddr;
  } mem_req_t;

  typedef struct packed {
    logic      load;
    out_item_t item;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LD_I,
    ST_SCAN,
    ST_WR_I,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/ascending_exchange_sorter.sv -----
// Top level of the ascending exchange sorter: store, sequencer and result register.
// Depends on exs_pkg, exs_store and exs_seq.
//
//   Channel | Direction | Handshake          | Request
//   src     | in        | src_valid/src_stall | in_item_t: key_value, last_in
//   dst     | out       | dst_valid/dst_stall | out_item_t: sorted_value, last_out, overflowed
//
// Values of a list are taken one per cycle until the request marked last.
// Sorting a list runs on the single comparator, with at most one store read and
// one store write per cycle. Each result is held in the result register while dst_stall
// is high; the next result is loaded only after it is taken.
// No new request is taken from the request marked last until the final result leaves.
// Reset is synchronous and clears the state, the fill count, the overflow flag and the valid bit.
`default_nettype none

module ascending_exchange_sorter (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 src_valid,
  output logic                src_stall,
  input  exs_pkg::in_item_t   src_item,
  output logic                dst_valid,
  input  wire                 dst_stall,
  output exs_pkg::out_item_t  dst_item
);
  import exs_pkg::*;

  mem_req_t mem_req;
  key_t     rdata;
  emit_t    emit;
  logic     taken;

  assign taken = dst_valid & ~dst_stall;

  exs_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  exs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .mem_req   (mem_req),
    .rdata     (rdata),
    .emit      (emit),
    .taken     (taken)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (emit.load) begin
      dst_valid <= 1'b1;
    end else if (taken) begin
      dst_valid <= 1'b0;
    end
    if (emit.load) begin
      dst_item <= emit.item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/exs_store.sv -----
// Value store of the sorter: one write port and one registered read port.
// Depends on exs_pkg for the request struct and the index types.
`default_nettype none

module exs_store (
  input  wire             clk,
  input  exs_pkg::mem_req_t req,
  output exs_pkg::key_t   rdata
);
  import exs_pkg::*;

  key_t mem [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/exs_seq.sv -----
// Sequencer of the sorter: collects a list, runs the exchange sort through one
// shared comparator over the store, then reads out the results. Uses exs_pkg.
`default_nettype none

module exs_seq (
  input  wire                clk,
  input  wire                rst,
  input  wire                src_valid,
  output logic               src_stall,
  input  exs_pkg::in_item_t  src_item,
  output exs_pkg::mem_req_t  mem_req,
  input  exs_pkg::key_t      rdata,
  output exs_pkg::emit_t     emit,
  input  wire                taken
);
  import exs_pkg::*;

  state_t state, state_next;
  cnt_t   fill, fill_next;
  logic   ovf, ovf_next;
  idx_t   i, i_next;
  idx_t   j, j_next;
  idx_t   k, k_next;
  key_t   held, held_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      ovf   <= ovf_next;
    end
    i    <= i_next;
    j    <= j_next;
    k    <= k_next;
    held <= held_next;
  end

  always_comb begin
    state_next    = state;
    fill_next     = fill;
    ovf_next      = ovf;
    i_next        = i;
    j_next        = j;
    k_next        = k;
    held_next     = held;
    src_stall     = 1'b1;
    mem_req.we    = 1'b0;
    mem_req.waddr = i;
    mem_req.wdata = held;
    mem_req.raddr = i;
    emit.load               = 1'b0;
    emit.item.sorted_value  = rdata;
    emit.item.last_out      = (cnt_t'(k) + cnt_t'(1)) == fill;
    emit.item.overflowed    = ovf;
    unique case (state)
      ST_IDLE: begin
        src_stall     = 1'b0;
        mem_req.waddr = fill[IDX_W-1:0];
        mem_req.wdata = src_item.key_value;
        if (src_valid) begin
          if (fill < cnt_t'(MAX_ENTRIES)) begin
            mem_req.we = 1'b1;
            fill_next  = fill + cnt_t'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (src_item.last_in) begin
            i_next     = '0;
            state_next = ST_RD_I;
          end
        end
      end
      ST_RD_I: begin
        if ((cnt_t'(i) + cnt_t'(1)) >= fill) begin
          mem_req.raddr = '0;
          k_next        = '0;
          state_next    = ST_EMIT_LD;
        end else begin
          mem_req.raddr = i;
          state_next    = ST_LD_I;
        end
      end
      ST_LD_I: begin
        held_next     = rdata;
        j_next        = i + idx_t'(1);
        mem_req.raddr = i + idx_t'(1);
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        mem_req.raddr = j + idx_t'(1);
        mem_req.waddr = j;
        mem_req.wdata = held;
        if (held > rdata) begin
          mem_req.we = 1'b1;
          held_next  = rdata;
        end
        if ((cnt_t'(j) + cnt_t'(1)) == fill) begin
          state_next = ST_WR_I;
        end else begin
          j_next = j + idx_t'(1);
        end
      end
      ST_WR_I: begin
        mem_req.we = 1'b1;
        i_next     = i + idx_t'(1);
        state_next = ST_RD_I;
      end
      ST_EMIT_LD: begin
        emit.load  = 1'b1;
        state_next = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        mem_req.raddr = k + idx_t'(1);
        if (taken) begin
          if ((cnt_t'(k) + cnt_t'(1)) == fill) begin
            fill_next  = '0;
            ovf_next   = 1'b0;
            state_next = ST_IDLE;
          end else begin
            k_next     = k + idx_t'(1);
            state_next = ST_EMIT_LD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/exs_checker.sv -----
// Port-level checks for the ascending exchange sorter, bound to its top level.
// Depends on exs_pkg and ascending_exchange_sorter_macros.svh.
`default_nettype none
`include "ascending_exchange_sorter_macros.svh"

module exs_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 src_valid,
  input wire                 src_stall,
  input exs_pkg::in_item_t   src_item,
  input wire                 dst_valid,
  input wire                 dst_stall,
  input exs_pkg::out_item_t  dst_item
);
  import exs_pkg::*;

  logic src_take;
  logic dst_wait;

  assign src_take = src_valid && !src_stall;
  assign dst_wait = dst_valid && dst_stall;

  `EXS_ASSERT_NEXT(a_dst_hold, dst_wait, dst_valid && $stable(dst_item), "stalled result changed")
  `EXS_ASSERT_NEXT(a_list_open, src_take && !src_item.last_in, !src_stall, "not ready mid list")
  `EXS_ASSERT_NEXT(a_busy_after_last, src_take && src_item.last_in, src_stall, "taken in sort")
  `EXS_ASSERT_SAME(a_no_take_on_emit, dst_valid, src_stall, "request taken while results pending")

endmodule

bind ascending_exchange_sorter exs_checker u_exs_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_item  (src_item),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ascending_exchange_sorter: sends lists of keys and checks
// every sorted result against a predicted sort of the same list.
// Depends on exs_pkg and the RTL of the block.

module tb;
  import exs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 125;
  localparam int PRINT_CAP = 40;

  logic clk;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  in_item_t src_item = '0;
  logic dst_valid;
  logic dst_stall = 1'b0;
  out_item_t dst_item;

  key_t list_keys [MAX_ENTRIES];
  int list_fill = 0;
  bit list_dropped = 1'b0;
  out_item_t pending_sorted_q [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  logic stall_level = 1'b0;

  ascending_exchange_sorter i_dut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_item  (src_item),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_item  (dst_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ascending_exchange_sorter: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  // Stores one accepted request and, on the request marked last, queues the sorted list.
  function automatic void absorb_request(input in_item_t req);
    key_t sorted [MAX_ENTRIES];
    key_t held;
    out_item_t res;
    if (list_fill < MAX_ENTRIES) begin
      list_keys[list_fill] = req.key_value;
      list_fill++;
    end else begin
      list_dropped = 1'b1;
    end
    if (req.last_in) begin
      for (int i = 0; i < list_fill; i++) sorted[i] = list_keys[i];
      for (int i = 0; i < list_fill; i++) begin
        for (int j = i + 1; j < list_fill; j++) begin
          if (sorted[i] > sorted[j]) begin
            held = sorted[i];
            sorted[i] = sorted[j];
            sorted[j] = held;
          end
        end
      end
      for (int k = 0; k < list_fill; k++) begin
        res.sorted_value = sorted[k];
        res.last_out = (k == list_fill - 1);
        res.overflowed = list_dropped;
        pending_sorted_q.push_back(res);
      end
      list_fill = 0;
      list_dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst) begin
      if (src_valid && !src_stall) absorb_request(src_item);
      if (dst_valid && !dst_stall) begin
        if (pending_sorted_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0d", dst_item.sorted_value));
        end else begin
          want = pending_sorted_q.pop_front();
          if (dst_item.sorted_value !== want.sorted_value)
            report_mismatch($sformatf("sorted_value got %0d want %0d",
                                      dst_item.sorted_value, want.sorted_value));
          if (dst_item.last_out !== want.last_out)
            report_mismatch($sformatf("last_out got %b want %b",
                                      dst_item.last_out, want.last_out));
          if (dst_item.overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %b want %b",
                                      dst_item.overflowed, want.overflowed));
        end
      end
    end
  end

  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_left == 0) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        stall_level = 1'b0;
        stall_left = $urandom_range(20, 60);
      end else if (r < 65) begin
        stall_level = 1'b0;
        stall_left = $urandom_range(1, 3);
      end else if (r < 95) begin
        stall_level = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_level = 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end
    stall_left = stall_left - 1;
    dst_stall <= stall_level;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Called right after a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input key_t key, input logic last, input bit no_gap);
    int gap;
    bit taken;
    in_item_t req;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      src_item <= in_item_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    req.key_value = key;
    req.last_in = last;
    src_valid <= 1'b1;
    src_item <= req;
    do begin
      @(negedge clk);
      taken = !src_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic test_single_value();
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b1, 1'b0);
  endtask

  task automatic test_extremes_and_ties();
    key_t keys [6] = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'h01, 8'hFE};
    for (int i = 0; i < 6; i++) send_request(keys[i], i == 5, 1'b0);
  endtask

  // A full store in descending order, then a last request that finds no room.
  task automatic test_store_overflow();
    for (int i = 0; i < MAX_ENTRIES; i++) send_request(key_t'((15 - i) * 17), 1'b0, 1'b0);
    send_request(8'hAA, 1'b1, 1'b0);
  endtask

  task automatic test_random_lists();
    int sent;
    int len;
    int r;
    bit burst;
    bit narrow;
    key_t key;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 1;
      else if (r < 75) len = $urandom_range(2, MAX_ENTRIES - 1);
      else if (r < 88) len = MAX_ENTRIES;
      else len = $urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 4);
      burst = ($urandom_range(0, 3) == 0);
      narrow = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        if (narrow) key = key_t'($urandom_range(0, 3));
        else if ($urandom_range(0, 9) == 0) key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else key = key_t'($urandom_range(0, 255));
        send_request(key, i == len - 1, burst);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_single_value();
    test_extremes_and_ties();
    test_store_overflow();
    test_random_lists();
    src_valid <= 1'b0;
    @(posedge clk);
    while (pending_sorted_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ascending_exchange_sorter: match");
    end else begin
      $display("ascending_exchange_sorter: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/exs_pkg.sv
rtl/exs_store.sv
rtl/exs_seq.sv
rtl/ascending_exchange_sorter.sv
rtl/exs_checker.sv
dv/tb.sv
